// ===== design/piq_pkg.sv =====
`timescale 1ns / 1ps
package piq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH   = 32;
    localparam int DEFAULT_IRQ_LINES     = 16;
    localparam int DEFAULT_PRIORITY_BITS = 8;

    localparam int MASK_BITS = 16;

    localparam logic OP_RAISE    = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [2:0] ST_QUEUED     = 3'd0;
    localparam logic [2:0] ST_DROPPED    = 3'd1;
    localparam logic [2:0] ST_HANDLED    = 3'd2;
    localparam logic [2:0] ST_NO_HANDLER = 3'd3;
    localparam logic [2:0] ST_NONE       = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [3:0] irq_number;
        logic [7:0] priority_req;
    } piq_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] served_irq;
        logic [7:0] served_priority;
        logic [5:0] pending_count;
    } piq_out_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } piq_cell_ctrl_t;

endpackage

// ===== design/piq_cell.sv =====
`timescale 1ns / 1ps
module piq_cell #(
    parameter int PRIORITY_BITS = 8
) (
    input  logic                       aclk,
    input  piq_pkg::piq_cell_ctrl_t    ctrl,
    input  logic                       occupied,
    input  logic [3:0]                 new_line,
    input  logic [PRIORITY_BITS-1:0]   new_prio,
    input  logic                       left_after,
    input  logic [3:0]                 left_line,
    input  logic [PRIORITY_BITS-1:0]   left_prio,
    input  logic [3:0]                 right_line,
    input  logic [PRIORITY_BITS-1:0]   right_prio,
    output logic                       after,
    output logic [3:0]                 line,
    output logic [PRIORITY_BITS-1:0]   prio
);
    import piq_pkg::*;

    logic [3:0]               line_reg, line_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;

    // at or behind the insertion point: empty, or strictly lower priority
    assign after = !occupied || (prio_reg < new_prio);

    always_comb begin
        line_next = line_reg;
        prio_next = prio_reg;
        priority if (ctrl.insert && after) begin
            if (left_after) begin
                line_next = left_line;
                prio_next = left_prio;
            end else begin
                line_next = new_line;
                prio_next = new_prio;
            end
        end else if (ctrl.pop) begin
            line_next = right_line;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg <= line_next;
        prio_reg <= prio_next;
    end

    assign line = line_reg;
    assign prio = prio_reg;

endmodule

// ===== design/priority_interrupt_queue_unit.sv =====
`timescale 1ns / 1ps
// The result of an accepted transaction is registered and appears on the m_ channel in the next cycle.
// Throughput: one transaction per cycle; each raise or dispatch is a single shift of
// the cell chain. A result held by m_ready low stalls s_ready; a new transaction enters
// in the same cycle as the held result is taken.
// Reset (aresetn low, synchronous) clears the entry count, the handler mask and the
// result valid; entry contents are left as they are.
module priority_interrupt_queue_unit #(
    parameter int QUEUE_DEPTH   = piq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int IRQ_LINES     = piq_pkg::DEFAULT_IRQ_LINES,
    parameter int PRIORITY_BITS = piq_pkg::DEFAULT_PRIORITY_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  piq_pkg::piq_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output piq_pkg::piq_out_t   m_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);
    import piq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [MASK_BITS-1:0]     mask_reg;
    logic                     m_valid_reg, m_valid_next;
    piq_out_t                 m_data_reg, m_data_next;

    logic                     accept;
    logic                     is_full, is_empty;
    logic                     has_handler;
    piq_cell_ctrl_t           ctrl;
    logic [PRIORITY_BITS-1:0] new_prio;

    logic [QUEUE_DEPTH-1:0]   occupied;
    logic [QUEUE_DEPTH-1:0]   cell_after;
    logic [3:0]               cell_line [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign new_prio = PRIORITY_BITS'(s_data.priority_req);

    assign ctrl.insert = accept && (s_data.opcode == OP_RAISE) && !is_full;
    assign ctrl.pop    = accept && (s_data.opcode == OP_DISPATCH) && !is_empty;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                     l_after;
            logic [3:0]               l_line;
            logic [PRIORITY_BITS-1:0] l_prio;
            logic [3:0]               r_line;
            logic [PRIORITY_BITS-1:0] r_prio;

            assign occupied[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_first
                assign l_after = 1'b0;
                assign l_line  = s_data.irq_number;
                assign l_prio  = new_prio;
            end else begin : g_inner_left
                assign l_after = cell_after[gi-1];
                assign l_line  = cell_line[gi-1];
                assign l_prio  = cell_prio[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                // hold the tail cell on a pop
                assign r_line = cell_line[gi];
                assign r_prio = cell_prio[gi];
            end else begin : g_inner_right
                assign r_line = cell_line[gi+1];
                assign r_prio = cell_prio[gi+1];
            end

            piq_cell #(
                .PRIORITY_BITS(PRIORITY_BITS)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (occupied[gi]),
                .new_line   (s_data.irq_number),
                .new_prio   (new_prio),
                .left_after (l_after),
                .left_line  (l_line),
                .left_prio  (l_prio),
                .right_line (r_line),
                .right_prio (r_prio),
                .after      (cell_after[gi]),
                .line       (cell_line[gi]),
                .prio       (cell_prio[gi])
            );
        end
    endgenerate

    assign has_handler = (int'(cell_line[0]) < IRQ_LINES) && mask_reg[cell_line[0]];

    always_comb begin
        count_next = count_reg;
        if (ctrl.insert) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next                = 1'b1;
            m_data_next.served_irq      = '0;
            m_data_next.served_priority = '0;
            m_data_next.pending_count   = 6'(count_next);
            if (s_data.opcode == OP_RAISE) begin
                m_data_next.status = is_full ? ST_DROPPED : ST_QUEUED;
            end else if (is_empty) begin
                m_data_next.status = ST_NONE;
            end else begin
                m_data_next.status          = has_handler ? ST_HANDLED : ST_NO_HANDLER;
                m_data_next.served_irq      = cell_line[0];
                m_data_next.served_priority = 8'(cell_prio[0]);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== test/priority_interrupt_queue_unit_test.sv =====
`timescale 1ns / 1ps
module priority_interrupt_queue_unit_test;
    import piq_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int LINES       = DEFAULT_IRQ_LINES;
    localparam int PRIO_BITS   = DEFAULT_PRIORITY_BITS;
    localparam logic [7:0] PRIO_KEEP = 8'((1 << PRIO_BITS) - 1);
    localparam int CYCLE_LIMIT = 150000;
    localparam int REPORT_MAX  = 10;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    piq_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    piq_out_t   m_data;
    logic       cfg_we;
    logic [15:0] cfg_wdata;

    // pending-interrupt model, sorted highest priority first
    logic [3:0]  line_q [DEPTH];
    logic [7:0]  prio_q [DEPTH];
    int          held;
    logic [15:0] mask_model;

    piq_out_t    awaited_results[$];
    int          fault_count;
    int          sent_count;
    int          checked_count;
    int          status_seen[5];
    int          mask_writes;
    int          cycle_count;
    int          sink_hold;
    bit          src_gaps;
    bit          sink_gaps;
    bit          quiet_run;

    priority_interrupt_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic piq_out_t predict_result(piq_in_t req);
        piq_out_t   res;
        logic [7:0] prio;
        logic [3:0] line;
        int         pos;
        int         i;
        res  = '0;
        prio = req.priority_req & PRIO_KEEP;
        if (req.opcode == OP_RAISE) begin
            if (held >= DEPTH) begin
                res.status = ST_DROPPED;
            end else begin
                // insert behind every entry of equal or higher priority
                pos = held;
                while (pos > 0 && prio_q[pos-1] < prio) begin
                    line_q[pos] = line_q[pos-1];
                    prio_q[pos] = prio_q[pos-1];
                    pos--;
                end
                line_q[pos] = req.irq_number;
                prio_q[pos] = prio;
                held++;
                res.status = ST_QUEUED;
            end
        end else if (held == 0) begin
            res.status = ST_NONE;
        end else begin
            line = line_q[0];
            res.served_irq      = line;
            res.served_priority = prio_q[0];
            if (int'(line) < LINES && int'(line) < MASK_BITS && mask_model[line])
                res.status = ST_HANDLED;
            else
                res.status = ST_NO_HANDLER;
            for (i = 1; i < held; i++) begin
                line_q[i-1] = line_q[i];
                prio_q[i-1] = prio_q[i];
            end
            held--;
        end
        res.pending_count = 6'(held);
        return res;
    endfunction

    // check results first, then record the transaction accepted at this edge
    always @(posedge aclk) begin
        piq_out_t want;
        if (!aresetn) begin
            held       = 0;
            mask_model = '0;
        end else begin
            if (m_valid && m_ready) begin
                checked_count++;
                if (m_data.status < 5)
                    status_seen[m_data.status]++;
                if (awaited_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("ERROR: unexpected result status=%0d irq=%0d prio=%0d count=%0d",
                                 m_data.status, m_data.served_irq, m_data.served_priority,
                                 m_data.pending_count);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.status !== want.status ||
                        m_data.served_irq !== want.served_irq ||
                        m_data.served_priority !== want.served_priority ||
                        m_data.pending_count !== want.pending_count) begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display({"ERROR: result %0d expected status=%0d irq=%0d prio=%0d ",
                                      "count=%0d, got status=%0d irq=%0d prio=%0d count=%0d"},
                                     checked_count, want.status, want.served_irq,
                                     want.served_priority, want.pending_count,
                                     m_data.status, m_data.served_irq,
                                     m_data.served_priority, m_data.pending_count);
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(predict_result(s_data));
            if (cfg_we)
                mask_model = cfg_wdata;
        end
    end

    // result side: random stall bursts, plus a long hold-off when asked
    initial begin
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (sink_gaps && !quiet_run && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("priority_interrupt_queue_unit verification failed");
        $finish;
    end

    // leaves valid high on return; the next call or wait_for_idle takes it over
    task automatic send_request(input piq_in_t req);
        int gap;
        if (src_gaps && !quiet_run && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_handler_mask(input logic [15:0] mask);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mask;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        mask_writes++;
    endtask

    function automatic piq_in_t make_request(input logic op, input int line, input int prio);
        piq_in_t req;
        req.opcode       = op;
        req.irq_number   = 4'(line);
        req.priority_req = 8'(prio);
        return req;
    endfunction

    function automatic piq_in_t rand_request(input int raise_pct);
        piq_in_t req;
        req.opcode     = ($urandom_range(0, 99) < raise_pct) ? OP_RAISE : OP_DISPATCH;
        req.irq_number = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0: req.priority_req = 8'($urandom_range(0, 3));   // crowd ties together
            1: req.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: req.priority_req = 8'($urandom);
        endcase
        return req;
    endfunction

    // bursts that lean towards filling, balancing or emptying the queue
    task automatic run_bursts(input int bursts);
        int raise_pct;
        repeat (bursts) begin
            case ($urandom_range(0, 2))
                0: raise_pct = 85;
                1: raise_pct = 50;
                default: raise_pct = 15;
            endcase
            src_gaps  = $urandom_range(0, 2) != 0;
            sink_gaps = $urandom_range(0, 2) != 0;
            repeat (20) send_request(rand_request(raise_pct));
        end
    endtask

    task automatic test_empty_and_order();
        write_handler_mask(16'hA5C3);
        send_request(make_request(OP_DISPATCH, 15, 255));
        send_request(make_request(OP_RAISE, 0, 0));
        send_request(make_request(OP_RAISE, 15, 255));
        send_request(make_request(OP_RAISE, 4, 128));
        send_request(make_request(OP_RAISE, 9, 128));
        send_request(make_request(OP_RAISE, 10, 128));
        send_request(make_request(OP_RAISE, 1, 255));
        send_request(make_request(OP_RAISE, 2, 0));
        repeat (4) send_request(make_request(OP_DISPATCH, 0, 0));
        repeat (4) send_request(make_request(OP_DISPATCH, 15, 255));
        wait_for_idle();
    endtask

    task automatic test_overflow();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        write_handler_mask(16'hFFFF);
        repeat (DEPTH + 2) send_request(rand_request(100));
        repeat (DEPTH + 1) send_request(rand_request(0));
        wait_for_idle();
    endtask

    task automatic test_output_stall();
        sink_hold = 250;
        repeat (48) send_request(rand_request(70));
        wait_for_idle();
    endtask

    task automatic test_mixed_traffic();
        logic [15:0] masks[5];
        masks = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h5555, 16'($urandom)};
        foreach (masks[k]) begin
            write_handler_mask(masks[k]);
            run_bursts(10);
        end
    endtask

    task automatic test_back_to_back();
        write_handler_mask(16'hAAAA);
        quiet_run = 1'b1;
        run_bursts(11);
        wait_for_idle();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        sink_hold   = 0;
        src_gaps    = 1'b0;
        sink_gaps   = 1'b0;
        quiet_run   = 1'b0;
        fault_count = 0;
        sent_count  = 0;
        checked_count = 0;
        mask_writes = 0;
        status_seen = '{default: 0};
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_and_order();
        test_overflow();
        test_output_stall();
        test_mixed_traffic();
        test_back_to_back();

        $display("Covered %0d transactions under %0d handler masks: %0d queued, %0d dropped full,",
                 sent_count, mask_writes, status_seen[ST_QUEUED], status_seen[ST_DROPPED]);
        $display("%0d served with handler, %0d without, %0d on an empty queue; %0d mismatches",
                 status_seen[ST_HANDLED], status_seen[ST_NO_HANDLER], status_seen[ST_NONE],
                 fault_count);
        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("priority_interrupt_queue_unit verification clean");
        end else begin
            if (awaited_results.size() != 0)
                $display("ERROR: %0d results never arrived", awaited_results.size());
            $display("priority_interrupt_queue_unit verification failed");
        end
        $finish;
    end

endmodule
